// File: rtl/core/fpti_pkg.sv
// ---------------------------------------------------------------------------
// fpti_pkg
// Shared types and constants for the pressure-to-flow table interpolator:
// table geometry, datapath widths, status and opcode codes, sequencer states
// and the control/status bundles of the serial divider.
// ---------------------------------------------------------------------------
package fpti_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CFG_W       = 7;

    // Field widths
    localparam int BP_W     = 24;
    localparam int CODE_W   = 8;
    localparam int FLOW_W   = 20;
    localparam int SEG_W    = 6;
    localparam int STATUS_W = 2;
    localparam int RAM_W    = BP_W + CODE_W;

    // Stream words
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 32;
    localparam int S_USED_W  = IDX_W + BP_W + CODE_W + BP_W;
    localparam int M_USED_W  = FLOW_W + SEG_W + STATUS_W;

    // Arithmetic widths
    localparam int FCODE_W = CODE_W + 1;        // flow code minus offset, signed
    localparam int DIFF_W  = BP_W + 1;          // breakpoint differences, signed
    localparam int PROD_W  = FCODE_W + DIFF_W;  // product of the two
    localparam int NUM_W   = PROD_W + 12;       // sum of products times 800
    localparam int DEN_SW  = DIFF_W + 2;        // 3 * d, signed
    localparam int DEN_W   = DEN_SW - 1;        // magnitude of 3 * d
    localparam int QUO_W   = FLOW_W;            // quotient bits produced
    localparam int QCNT_W  = $clog2(QUO_W);

    // Flow byte offset in l/min
    localparam int FLOW_OFFSET = 100;

    // Saturation limits of the flow result
    localparam logic [FLOW_W-1:0] FLOW_MAX = {1'b0, {(FLOW_W-1){1'b1}}};
    localparam logic [FLOW_W-1:0] FLOW_MIN = {1'b1, {(FLOW_W-1){1'b0}}};

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_LOAD   = 1'b1
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_ZERO_WIDTH = 2'd1,
        ST_SAT        = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_CMP,
        S_RD0,
        S_RD1,
        S_MUL,
        S_SCALE,
        S_START,
        S_DIV,
        S_DONE
    } state_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic overflow;
    } div_stat_t;

endpackage

// File: rtl/core/fpti_ram.sv
// ---------------------------------------------------------------------------
// fpti_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module fpti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/fpti_div.sv
// ---------------------------------------------------------------------------
// fpti_div
// Serial restoring divider on magnitudes. Flags a quotient that does not fit
// in QUO_W bits up front, otherwise develops one quotient bit per cycle.
// ---------------------------------------------------------------------------
module fpti_div
    import fpti_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  div_ctrl_t        ctrl,
    input  logic [NUM_W-1:0] num_mag,
    input  logic [DEN_W-1:0] den_mag,
    output div_stat_t        stat,
    output logic [QUO_W-1:0] quotient
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              ovf_reg, ovf_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0]  rem_reg, rem_next;
    logic [NUM_W-1:0]  dvs_reg, dvs_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [NUM_W:0]    trial;

    // Trial subtraction of the shifted divisor
    assign trial = {1'b0, rem_reg} - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (ctrl.start) begin
            // Load operands, check the quotient range
            rem_next  = num_mag;
            dvs_next  = NUM_W'(den_mag) << (QUO_W - 1);
            quo_next  = '0;
            cnt_next  = QCNT_W'(QUO_W - 1);
            ovf_next  = num_mag >= (NUM_W'(den_mag) << QUO_W);
            busy_next = !ovf_next;
            done_next = ovf_next;
        end else if (busy_reg) begin
            // One quotient bit per cycle
            if (!trial[NUM_W]) begin
                rem_next = trial[NUM_W-1:0];
            end
            quo_next = {quo_reg[QUO_W-2:0], !trial[NUM_W]};
            dvs_next = dvs_reg >> 1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        ovf_reg <= ovf_next;
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign stat.busy     = busy_reg;
    assign stat.done     = done_reg;
    assign stat.overflow = ovf_reg;
    assign quotient      = quo_reg;

    // The divider never reports done while still iterating
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");

    // A start is only issued to an idle divider
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.start |-> !busy_reg)
        else $error("divider started while busy");

    // In range, the remainder stays below twice the current divisor
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> ({1'b0, rem_reg} < {dvs_reg, 1'b0}))
        else $error("divider remainder out of range");

endmodule

// File: rtl/core/flow_from_pressure_table_interp_top.sv
// ---------------------------------------------------------------------------
// flow_from_pressure_table_interp_top
// Pressure-to-flow conversion by piecewise-linear calibration table lookup.
//
//   Channel   Dir  Handshake          Contents
//   s_*       in   s_tvalid/s_tready  s_tuser = opcode (1 = load, 0 = lookup),
//                                     s_tdata = entry and query fields
//   m_*       out  m_tvalid/m_tready  m_tdata = flow_rate, segment_index, status
//   cfg_*     in   cfg_we             cfg_wdata = entries_used
//
// Load words can stream back to back. A lookup runs a binary search over the
// active entries (at most 6 steps for 64 entries), each search step waiting
// on the registered table read, then runs the 20-step serial divider. A
// zero-width segment skips the divider; a quotient out of range is flagged
// when the divide starts and ends it without iterating. s_tready is high only
// while the sequencer is idle.
// Reset is synchronous, active low; the table is not cleared and must be
// loaded before lookups. A result still waiting on m_tready when the next one
// is ready holds the sequencer in its final state and blocks further input.
// ---------------------------------------------------------------------------
module flow_from_pressure_table_interp_top
    import fpti_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration: entries_used
    input  logic                 cfg_we,
    input  logic [CFG_W-1:0]     cfg_wdata,
    // Input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [5:0] entry_index, [29:6] entry_pressure, [37:30] entry_flow_code,
    // [61:38] query_pressure, [63:62] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [0] opcode
    input  logic                 s_tuser,
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [19:0] flow_rate, [25:20] segment_index, [27:26] status, [31:28] zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    state_t state_reg, state_next;

    logic [CFG_W-1:0] entries_used_reg;
    logic [CNT_W-1:0] entries_ext;
    logic [CNT_W-1:0] n_active;

    logic [IDX_W-1:0] lo_reg, lo_next;
    logic [IDX_W-1:0] hi_reg, hi_next;
    logic [IDX_W-1:0] mid_reg, mid_next;
    logic [IDX_W-1:0] mid_calc;
    logic [IDX_W-1:0] lo_plus1;
    logic             span_gt1;

    logic signed [BP_W-1:0]    q_reg, q_next;
    logic signed [BP_W-1:0]    b0_reg, b0_next;
    logic [CODE_W-1:0]         c0_reg, c0_next;
    logic signed [FCODE_W-1:0] f0_reg, f0_next;
    logic signed [FCODE_W-1:0] df_reg, df_next;
    logic signed [DIFF_W-1:0]  d_reg, d_next;
    logic signed [DIFF_W-1:0]  qd_reg, qd_next;
    logic signed [PROD_W-1:0]  p0_reg, p0_next;
    logic signed [PROD_W-1:0]  p1_reg, p1_next;
    logic signed [NUM_W-1:0]   num_reg, num_next;
    logic signed [DEN_SW-1:0]  den_reg, den_next;
    logic                      zero_reg, zero_next;
    logic signed [NUM_W-1:0]   sum_w;
    logic signed [DEN_SW-1:0]  d_ext;

    logic [FLOW_W-1:0] res_flow_reg, res_flow_next;
    status_t           res_status_reg, res_status_next;

    logic              m_valid_reg, m_valid_next;
    logic [FLOW_W-1:0] m_flow_reg, m_flow_next;
    logic [SEG_W-1:0]  m_seg_reg, m_seg_next;
    status_t           m_status_reg, m_status_next;

    // Table port
    logic             ram_we;
    logic [IDX_W-1:0] ram_raddr;
    logic [RAM_W-1:0] ram_rdata;
    logic signed [BP_W-1:0] rd_bp;
    logic [CODE_W-1:0]      rd_code;

    // Divider
    div_ctrl_t        div_ctrl;
    div_stat_t        div_stat;
    logic [NUM_W-1:0] num_mag;
    logic [DEN_W-1:0] den_mag;
    logic [QUO_W-1:0] quotient;
    logic             neg;
    logic             sat;
    logic [FLOW_W-1:0] flow_val;

    // Input fields
    logic [IDX_W-1:0]       in_index;
    logic [BP_W-1:0]        in_bp;
    logic [CODE_W-1:0]      in_code;
    logic signed [BP_W-1:0] in_query;
    logic                   s_accept;

    assign in_index = s_tdata[IDX_W-1:0];
    assign in_bp    = s_tdata[IDX_W +: BP_W];
    assign in_code  = s_tdata[IDX_W+BP_W +: CODE_W];
    assign in_query = s_tdata[IDX_W+BP_W+CODE_W +: BP_W];
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // Clamp the active entry count into [2, TABLE_DEPTH]
    assign entries_ext = CNT_W'(entries_used_reg);
    always_comb begin
        if (entries_ext < CNT_W'(2)) begin
            n_active = CNT_W'(2);
        end else if (entries_ext > CNT_W'(TABLE_DEPTH)) begin
            n_active = CNT_W'(TABLE_DEPTH);
        end else begin
            n_active = entries_ext;
        end
    end

    // Search bracket arithmetic
    assign mid_calc = IDX_W'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
    assign lo_plus1 = lo_reg + IDX_W'(1);
    assign span_gt1 = (hi_reg - lo_reg) > IDX_W'(1);

    // Table: breakpoint in the low bits, flow code above
    assign ram_we  = s_accept && (opcode_t'(s_tuser) == OP_LOAD);
    assign rd_bp   = ram_rdata[BP_W-1:0];
    assign rd_code = ram_rdata[BP_W +: CODE_W];

    always_comb begin
        case (state_reg)
            S_CHECK: ram_raddr = span_gt1 ? mid_calc : lo_reg;
            S_RD0:   ram_raddr = lo_plus1;
            default: ram_raddr = lo_reg;
        endcase
    end

    fpti_ram #(
        .WIDTH (RAM_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (in_index),
        .wdata ({in_code, in_bp}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Divider operands as magnitudes
    assign num_mag = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
    assign den_mag = den_reg[DEN_SW-1] ? DEN_W'(-den_reg) : DEN_W'(den_reg);
    assign neg     = num_reg[NUM_W-1] ^ den_reg[DEN_SW-1];

    fpti_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (div_ctrl),
        .num_mag  (num_mag),
        .den_mag  (den_mag),
        .stat     (div_stat),
        .quotient (quotient)
    );

    // Sign and saturate the quotient
    assign sat = div_stat.overflow
              || (quotient[QUO_W-1] && (!neg || (|quotient[QUO_W-2:0])));
    always_comb begin
        if (sat) begin
            flow_val = neg ? FLOW_MIN : FLOW_MAX;
        end else if (neg) begin
            flow_val = FLOW_W'(~quotient + QUO_W'(1));
        end else begin
            flow_val = FLOW_W'(quotient);
        end
    end

    // Scale helpers: 800 = 512 + 256 + 32, 3 * d = 2 * d + d
    assign sum_w = NUM_W'(p0_reg) + NUM_W'(p1_reg);
    assign d_ext = DEN_SW'(d_reg);

    // Sequencer: next state and datapath updates
    always_comb begin
        state_next      = state_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        q_next          = q_reg;
        b0_next         = b0_reg;
        c0_next         = c0_reg;
        f0_next         = f0_reg;
        df_next         = df_reg;
        d_next          = d_reg;
        qd_next         = qd_reg;
        p0_next         = p0_reg;
        p1_next         = p1_reg;
        num_next        = num_reg;
        den_next        = den_reg;
        zero_next       = zero_reg;
        res_flow_next   = res_flow_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg;
        m_flow_next     = m_flow_reg;
        m_seg_next      = m_seg_reg;
        m_status_next   = m_status_reg;
        div_ctrl.start  = 1'b0;

        // Drop the result word once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_accept && (opcode_t'(s_tuser) == OP_LOOKUP)) begin
                    q_next     = in_query;
                    lo_next    = '0;
                    hi_next    = IDX_W'(n_active - CNT_W'(1));
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                // Issue the midpoint read, or the segment read when done
                if (span_gt1) begin
                    mid_next   = mid_calc;
                    state_next = S_CMP;
                end else begin
                    state_next = S_RD0;
                end
            end
            S_CMP: begin
                if (q_reg < rd_bp) begin
                    hi_next = mid_reg;
                end else begin
                    lo_next = mid_reg;
                end
                state_next = S_CHECK;
            end
            S_RD0: begin
                // Lower entry of the segment
                b0_next    = rd_bp;
                c0_next    = rd_code;
                f0_next    = $signed({1'b0, rd_code} - FCODE_W'(FLOW_OFFSET));
                qd_next    = DIFF_W'(q_reg) - DIFF_W'(rd_bp);
                state_next = S_RD1;
            end
            S_RD1: begin
                // Upper entry of the segment
                d_next     = DIFF_W'(rd_bp) - DIFF_W'(b0_reg);
                df_next    = $signed({1'b0, rd_code} - {1'b0, c0_reg});
                state_next = S_MUL;
            end
            S_MUL: begin
                p0_next    = PROD_W'(f0_reg) * PROD_W'(d_reg);
                p1_next    = PROD_W'(df_reg) * PROD_W'(qd_reg);
                state_next = S_SCALE;
            end
            S_SCALE: begin
                num_next   = (sum_w <<< 9) + (sum_w <<< 8) + (sum_w <<< 5);
                den_next   = (d_ext <<< 1) + d_ext;
                zero_next  = (d_reg == '0);
                state_next = S_START;
            end
            S_START: begin
                if (zero_reg) begin
                    res_flow_next   = '0;
                    res_status_next = ST_ZERO_WIDTH;
                    state_next      = S_DONE;
                end else begin
                    div_ctrl.start = 1'b1;
                    state_next     = S_DIV;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    res_flow_next   = flow_val;
                    res_status_next = sat ? ST_SAT : ST_OK;
                    state_next      = S_DONE;
                end
            end
            S_DONE: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_flow_next   = res_flow_reg;
                    m_seg_next    = SEG_W'(lo_reg);
                    m_status_next = res_status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            m_valid_reg      <= 1'b0;
            entries_used_reg <= CFG_W'(TABLE_DEPTH);
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                entries_used_reg <= cfg_wdata;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        q_reg          <= q_next;
        b0_reg         <= b0_next;
        c0_reg         <= c0_next;
        f0_reg         <= f0_next;
        df_reg         <= df_next;
        d_reg          <= d_next;
        qd_reg         <= qd_next;
        p0_reg         <= p0_next;
        p1_reg         <= p1_next;
        num_reg        <= num_next;
        den_reg        <= den_next;
        zero_reg       <= zero_next;
        res_flow_reg   <= res_flow_next;
        res_status_reg <= res_status_next;
        m_flow_reg     <= m_flow_next;
        m_seg_reg      <= m_seg_next;
        m_status_reg   <= m_status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-M_USED_W){1'b0}}, m_status_reg, m_seg_reg, m_flow_reg};

    // The midpoint stays strictly inside the search bracket
    a_mid_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CMP) |-> ((lo_reg < mid_reg) && (mid_reg < hi_reg)))
        else $error("search midpoint outside bracket");

    // The bracket never collapses during the search
    a_bracket: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CHECK) |-> (lo_reg < hi_reg))
        else $error("search bracket collapsed");

    // Divider completion only while the sequencer waits for it
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == S_DIV))
        else $error("divider done outside divide state");

    // A saturated result carries one of the two limits
    a_sat_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg == ST_SAT))
        |-> ((m_flow_reg == FLOW_MAX) || (m_flow_reg == FLOW_MIN)))
        else $error("saturated flow not at a limit");

    // A zero-width segment yields zero flow
    a_zero_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg == ST_ZERO_WIDTH)) |-> (m_flow_reg == '0))
        else $error("zero-width segment with nonzero flow");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Testbench for the pressure-to-flow table interpolator
// Loads calibration tables of several shapes (ascending, with repeated
// breakpoints, descending, random, steep), looks up flows and checks every
// result word against an in-bench interpolator. It runs through several
// entries_used settings, with random sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
module testbench;
    import fpti_pkg::*;

    localparam int DRAIN_CYCLES = 48;
    localparam int STALL_LIMIT  = 3000;  // cycles without any handshake

    typedef struct {
        logic [FLOW_W-1:0] flow;
        logic [SEG_W-1:0]  seg;
        status_t           status;
    } flow_result_t;

    // Table copy, flow interpolation and the queue of expected result words
    class flow_checker;
        logic signed [BP_W-1:0] bp_table [TABLE_DEPTH];
        logic [CODE_W-1:0]      code_table [TABLE_DEPTH];
        logic [CFG_W-1:0]       entries_used = 7'd64;
        flow_result_t           pending_flows [$];
        int                     errors = 0;

        function void set_entries_used(logic [CFG_W-1:0] value);
            entries_used = value;
        endfunction

        function int pending();
            return pending_flows.size();
        endfunction

        function flow_result_t interpolate_flow(logic signed [BP_W-1:0] q);
            int n, lo, hi, mid;
            longint b0, b1, f0, f1, d, num, v;
            flow_result_t r;
            n = int'(entries_used);
            if (n < 2) n = 2;
            if (n > TABLE_DEPTH) n = TABLE_DEPTH;
            // binary search for the segment [lo, lo + 1]
            lo = 0;
            hi = n - 1;
            while (hi - lo > 1) begin
                mid = (lo + hi) / 2;
                if (q < bp_table[mid]) hi = mid;
                else lo = mid;
            end
            b0 = bp_table[lo];
            b1 = bp_table[lo + 1];
            f0 = longint'(code_table[lo]) - FLOW_OFFSET;
            f1 = longint'(code_table[lo + 1]) - FLOW_OFFSET;
            d  = b1 - b0;
            r.seg = lo[SEG_W-1:0];
            if (d == 0) begin
                r.flow   = '0;
                r.status = ST_ZERO_WIDTH;
            end else begin
                // l/min to ml/s is 50/3, Q.4 makes it 800/3; divide truncates to zero
                num = 800 * (f0 * d + (f1 - f0) * (longint'(q) - b0));
                v   = num / (3 * d);
                r.status = ST_OK;
                if (v > 524287) begin
                    v = 524287;
                    r.status = ST_SAT;
                end else if (v < -524288) begin
                    v = -524288;
                    r.status = ST_SAT;
                end
                r.flow = v[FLOW_W-1:0];
            end
            return r;
        endfunction

        // Apply an accepted input word: store a load, predict a lookup
        function void apply_word(opcode_t op, logic [S_TDATA_W-1:0] data);
            if (op == OP_LOAD) begin
                bp_table[data[5:0]]   = data[29:6];
                code_table[data[5:0]] = data[37:30];
            end else begin
                pending_flows.push_back(interpolate_flow(data[61:38]));
            end
        endfunction

        // Compare a result word field by field with the oldest prediction
        function void compare_result(logic [M_TDATA_W-1:0] word);
            flow_result_t want;
            if (pending_flows.size() == 0) begin
                $error("unexpected result word %h", word);
                errors++;
                return;
            end
            want = pending_flows.pop_front();
            if (word[19:0] !== want.flow) begin
                $error("flow_rate: expected %0d, got %0d",
                       $signed(want.flow), $signed(word[19:0]));
                errors++;
            end
            if (word[25:20] !== want.seg) begin
                $error("segment_index: expected %0d, got %0d", want.seg, word[25:20]);
                errors++;
            end
            if (word[27:26] !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, word[27:26]);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    flow_checker sb;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int quiet_cycles = 0;

    // Stimulus copy of the table, used to aim queries at segments
    logic signed [BP_W-1:0] tbl_bp [TABLE_DEPTH];
    logic [CODE_W-1:0]      tbl_code [TABLE_DEPTH];

    flow_from_pressure_table_interp_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Receiver: stall at random at the rate of the current phase
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Check each accepted result word
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.compare_result(m_tdata);
        end
    end

    // Watchdog: end the run when no word moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    function automatic logic [S_TDATA_W-1:0] pack_item(logic [5:0] idx,
            logic [BP_W-1:0] ep, logic [CODE_W-1:0] code, logic [BP_W-1:0] q);
        return {2'b00, q, code, ep, idx};
    endfunction

    // Send one input word, with random gaps, and hold until accepted
    task automatic send_word(opcode_t op, logic [S_TDATA_W-1:0] data);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        sb.apply_word(op, data);
    endtask

    task automatic load_entry(int idx, logic [BP_W-1:0] ep, logic [CODE_W-1:0] code);
        tbl_bp[idx]   = ep;
        tbl_code[idx] = code;
        send_word(OP_LOAD, pack_item(idx[5:0], ep, code, BP_W'($urandom)));
    endtask

    task automatic lookup(logic [BP_W-1:0] q);
        send_word(OP_LOOKUP, pack_item(6'($urandom), BP_W'($urandom), CODE_W'($urandom), q));
    endtask

    // Wait out every expected result, then the tail of the last item
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_entries_used(logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.set_entries_used(value);
        cfg_we    <= 1'b0;
    endtask

    // Build a table of the given shape in entries 0 .. n-1 and load it
    task automatic load_table(int shape, int n);
        longint p, step;
        logic signed [BP_W-1:0] tmp;
        int i;
        step = (longint'(16777215) / n) >> $urandom_range(0, 10);
        if (shape == 4) step = 4;
        if (step < 1) step = 1;
        p = -8388608 + longint'($urandom_range(0, int'(step)));
        for (i = 0; i < n; i++) begin
            if (shape == 3) begin
                tbl_bp[i] = BP_W'($urandom);
            end else begin
                tbl_bp[i] = (p > 8388607) ? 24'h7FFFFF : p[23:0];
                // repeat a breakpoint now and then in the duplicate shape
                if (!(shape == 1 && $urandom_range(2) == 0))
                    p += $urandom_range(1, int'(step));
            end
            tbl_code[i] = (shape == 4) ? ($urandom_range(1) ? 8'hFF : 8'h00) : 8'($urandom);
        end
        if (shape == 2) begin
            for (i = 0; i < n / 2; i++) begin
                tmp = tbl_bp[i];
                tbl_bp[i] = tbl_bp[n - 1 - i];
                tbl_bp[n - 1 - i] = tmp;
            end
        end
        for (i = 0; i < n; i++) load_entry(i, tbl_bp[i], tbl_code[i]);
    endtask

    // Mostly queries aimed at segments, some breakpoints, noise and extremes
    task automatic run_lookups(int n, int count);
        int c, k, pick;
        longint a, b, q;
        for (c = 0; c < count; c++) begin
            if ($urandom_range(9) == 0)
                load_entry($urandom_range(TABLE_DEPTH - 1), BP_W'($urandom),
                           CODE_W'($urandom));
            k = $urandom_range(0, n - 2);
            a = tbl_bp[k];
            b = tbl_bp[k + 1];
            if (a > b) begin
                q = a;
                a = b;
                b = q;
            end
            pick = $urandom_range(99);
            if (pick < 55)
                q = a + $urandom_range(0, int'(b - a));
            else if (pick < 70)
                q = longint'(tbl_bp[$urandom_range(0, n - 1)]) + $urandom_range(0, 2) - 1;
            else if (pick < 90)
                q = $urandom;
            else
                q = $urandom_range(1) ? 8388607 : -8388608;
            lookup(q[23:0]);
        end
    endtask

    initial begin
        logic [CFG_W-1:0] settings [14];
        int i, n;
        settings = '{7'd64, 7'd2, 7'd0, 7'd1, 7'd127, 7'd65, 7'd3, 7'd8, 7'd17,
                     7'd33, 7'd64, 7'd0, 7'd5, 7'd64};
        settings[11] = CFG_W'($urandom_range(0, 127));
        sb = new;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Fill the whole table: ascending, end points at the pressure extremes
        for (i = 0; i < TABLE_DEPTH; i++)
            load_entry(i, 24'(-8388608 + i * 266305),
                       (i == 0) ? 8'h00 : (i == 63) ? 8'hFF : 8'($urandom));

        // Extremes of the query and exact breakpoints
        lookup(24'h800000);
        lookup(24'h7FFFFF);
        lookup(tbl_bp[32]);
        lookup(BP_W'(tbl_bp[32] - 1));
        lookup(BP_W'(tbl_bp[32] + 1));
        lookup(24'((longint'(tbl_bp[5]) + longint'(tbl_bp[6])) / 2));
        // Zero-width last segment, then a repeated first breakpoint
        load_entry(62, 24'h7FFFFF, 8'd40);
        lookup(24'h7FFFFF);
        load_entry(1, 24'h800000, 8'd200);
        lookup(24'h800000);
        // Steep last segment extrapolated upward: saturates high
        load_entry(62, 24'd0, 8'h00);
        load_entry(63, 24'd1, 8'hFF);
        lookup(24'h7FFFFF);
        // Steep first segment extrapolated downward: saturates low
        load_entry(0, 24'd100, 8'h00);
        load_entry(1, 24'd101, 8'hFF);
        lookup(24'h800000);
        drain();

        // Random phases: new setting, new table, lookups under varied idling
        for (i = 1; i < 14; i++) begin
            case (i % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 68; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 68; end
                default: begin tx_idle_pct = 37; rx_stall_pct = 37; end
            endcase
            write_entries_used(settings[i]);
            n = int'(settings[i]);
            if (n < 2) n = 2;
            if (n > TABLE_DEPTH) n = TABLE_DEPTH;
            load_table(i % 5, n);
            run_lookups(n, 60);
            drain();
        end

        if (sb.pending() != 0) begin
            $error("%0d expected result words never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
